>>> sv/assert_macros.svh
// assertion macros included by aes_block_decrypt
// depends on nothing; the user module supplies clk and arst_n
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define AESD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// property that must hold in the cycle after a trigger
`define AESD_ASSERT_NEXT(lbl, trig, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (prop)) \
		else $error(msg);

`endif

>>> sv/aesd_pkg.sv
// types, constants and byte functions of the aes inverse cipher
// depends on nothing
package aesd_pkg;

	localparam logic OP_LOAD    = 1'b0;
	localparam logic OP_DECRYPT = 1'b1;

	localparam logic [7:0] MUL_E = 8'h0E;
	localparam logic [7:0] MUL_B = 8'h0B;
	localparam logic [7:0] MUL_D = 8'h0D;
	localparam logic [7:0] MUL_9 = 8'h09;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ADDK,
		ST_ROUND
	} state_t;

	// per-cycle command to every column cell
	typedef struct packed {
		logic load;
		logic addk;
		logic rnd;
		logic mix;
	} cell_ctl_t;

	localparam logic [7:0] INV_SBOX [256] = '{
		8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
		8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
		8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
		8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
		8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
		8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
		8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
		8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
		8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
		8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
		8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
		8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
		8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
		8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
		8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
		8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
	};

	// gf(2^8) multiply, aes polynomial
	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] p;
		logic [7:0] x;
		p = 8'h00;
		x = a;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) p = p ^ x;
			x = {x[6:0], 1'b0} ^ (x[7] ? 8'h1B : 8'h00);
		end
		return p;
	endfunction

	// inverse mix of one column, row 0 in the top byte
	function automatic logic [31:0] inv_mix_col(input logic [31:0] col);
		logic [7:0] a [4];
		logic [31:0] res;
		for (int r = 0; r < 4; r++) a[r] = col[31-8*r -: 8];
		for (int r = 0; r < 4; r++) begin
			res[31-8*r -: 8] = gf_mul(a[r], MUL_E) ^ gf_mul(a[(r+1)%4], MUL_B)
				^ gf_mul(a[(r+2)%4], MUL_D) ^ gf_mul(a[(r+3)%4], MUL_9);
		end
		return res;
	endfunction

endpackage

>>> sv/aesd_ifs.sv
// valid/ready channel interfaces of the aes inverse cipher
// depends on nothing
interface aesd_req_if;
	logic        valid;
	logic        ready;
	logic        operation;
	logic [4:0]  key_index;
	logic [63:0] data_hi;
	logic [63:0] data_lo;
	modport source (output valid, operation, key_index, data_hi, data_lo, input ready);
	modport sink (input valid, operation, key_index, data_hi, data_lo, output ready);
endinterface

interface aesd_rsp_if;
	logic        valid;
	logic        ready;
	logic [63:0] plain_hi;
	logic [63:0] plain_lo;
	modport source (output valid, plain_hi, plain_lo, input ready);
	modport sink (input valid, plain_hi, plain_lo, output ready);
endinterface

>>> sv/aesd_col_cell.sv
// one state column of the inverse cipher: shift-in, inverse sbox, key add, inverse mix
// depends on aesd_pkg
module aesd_col_cell (
	input  logic                clk,
	input  aesd_pkg::cell_ctl_t ctl,
	input  logic [31:0]         load_col,
	input  logic [31:0]         shift_col,
	input  logic [31:0]         key_col,
	output logic [31:0]         col_q,
	output logic [31:0]         col_d
);
	import aesd_pkg::*;

	logic [31:0] sub_col;
	logic [31:0] rk_col;

	// inverse sbox on the shifted bytes: row 0 from this column, rows 1 to 3 from the neighbors
	always_comb begin
		for (int r = 0; r < 4; r++) sub_col[31-8*r -: 8] = INV_SBOX[shift_col[31-8*r -: 8]];
		rk_col = sub_col ^ key_col;
	end

	// next column value
	always_comb begin
		if (ctl.load) col_d = load_col;
		else if (ctl.addk) col_d = col_q ^ key_col;
		else if (ctl.rnd) col_d = ctl.mix ? inv_mix_col(rk_col) : rk_col;
		else col_d = col_q;
	end

	// column register
	always_ff @(posedge clk) begin
		col_q <= col_d;
	end
endmodule

>>> sv/aes_block_decrypt.sv
// Decrypt: accept and load, key add, then the rounds, the last one without inverse mix and
// held while the result is unread. One block at a time, set by the single round datapath
// of four cells; the result register frees the engine for the next item.
// Reset clears the sequencer and result valid; key store contents are undefined until loaded.
// depends on aesd_pkg, aesd_ifs, aesd_col_cell, assert_macros.svh
module aes_block_decrypt #(
	parameter int ROUNDS = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	aesd_req_if.sink    req,
	aesd_rsp_if.source  rsp
);
	import aesd_pkg::*;
	`include "assert_macros.svh"

	localparam int RW = $clog2(ROUNDS + 1);
	localparam int KEY_HALVES = 2 * (ROUNDS + 1);
	localparam logic [RW-1:0] LAST_RND = RW'(ROUNDS);
	localparam logic [RW-1:0] FIRST_INV = RW'(ROUNDS - 1);
	localparam logic [RW-1:0] RND_ZERO = '0;

	state_t        state_q, state_d;
	logic [RW-1:0] round_q, round_d;
	logic [RW-1:0] rd_addr;
	cell_ctl_t     ctl;
	logic          in_take;
	logic          out_free;
	logic          finish;
	logic          out_valid_q;
	logic [63:0]   out_hi_q, out_lo_q;

	logic [63:0]   key_hi_mem [ROUNDS+1];
	logic [63:0]   key_lo_mem [ROUNDS+1];
	logic [63:0]   key_hi_q, key_lo_q;

	logic [31:0]   col_q [4];
	logic [31:0]   col_d [4];
	logic [31:0]   load_col [4];
	logic [31:0]   key_col [4];
	logic [31:0]   shift_col [4];

	assign req.ready = (state_q == ST_IDLE);
	assign in_take   = req.valid && req.ready;
	assign out_free  = !out_valid_q || rsp.ready;

	// sequencer: next state, cell command and key read address
	always_comb begin
		state_d = state_q;
		round_d = round_q;
		rd_addr = round_q;
		ctl     = '0;
		finish  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_take && req.operation == OP_DECRYPT) begin
					ctl.load = 1'b1;
					rd_addr  = LAST_RND;
					state_d  = ST_ADDK;
				end
			end
			ST_ADDK: begin
				ctl.addk = 1'b1;
				rd_addr  = FIRST_INV;
				round_d  = FIRST_INV;
				state_d  = ST_ROUND;
			end
			ST_ROUND: begin
				if (round_q != RND_ZERO) begin
					ctl.rnd = 1'b1;
					ctl.mix = 1'b1;
					round_d = round_q - 1'b1;
					rd_addr = round_q - 1'b1;
				end else if (out_free) begin
					ctl.rnd = 1'b1;
					finish  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			round_q <= '0;
		end else begin
			state_q <= state_d;
			round_q <= round_d;
		end
	end

	// round key store, halves in separate memories, registered read
	always_ff @(posedge clk) begin
		if (in_take && req.operation == OP_LOAD && req.key_index < 5'(KEY_HALVES)) begin
			if (req.key_index[0]) key_lo_mem[req.key_index[RW:1]] <= req.data_hi;
			else key_hi_mem[req.key_index[RW:1]] <= req.data_hi;
		end
		key_hi_q <= key_hi_mem[rd_addr];
		key_lo_q <= key_lo_mem[rd_addr];
	end

	// column wiring: load, key and inverse shift rows between neighbors
	always_comb begin
		load_col[0] = req.data_hi[63:32];
		load_col[1] = req.data_hi[31:0];
		load_col[2] = req.data_lo[63:32];
		load_col[3] = req.data_lo[31:0];
		key_col[0]  = key_hi_q[63:32];
		key_col[1]  = key_hi_q[31:0];
		key_col[2]  = key_lo_q[63:32];
		key_col[3]  = key_lo_q[31:0];
		for (int c = 0; c < 4; c++) begin
			shift_col[c] = {col_q[c][31:24], col_q[(c+3)%4][23:16],
				col_q[(c+2)%4][15:8], col_q[(c+1)%4][7:0]};
		end
	end

	// row of column cells
	for (genvar c = 0; c < 4; c++) begin : g_col
		aesd_col_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.load_col  (load_col[c]),
			.shift_col (shift_col[c]),
			.key_col   (key_col[c]),
			.col_q     (col_q[c]),
			.col_d     (col_d[c])
		);
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (finish) out_valid_q <= 1'b1;
		else if (rsp.ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			out_hi_q <= {col_d[0], col_d[1]};
			out_lo_q <= {col_d[2], col_d[3]};
		end
	end

	assign rsp.valid    = out_valid_q;
	assign rsp.plain_hi = out_hi_q;
	assign rsp.plain_lo = out_lo_q;

	// checks
	`AESD_ASSERT(a_busy_not_ready, (state_q != ST_IDLE) |-> !req.ready, "ready while busy")
	`AESD_ASSERT_NEXT(a_round_dec, (state_q == ST_ROUND && round_q != RND_ZERO),
		(round_q == $past(round_q) - 1'b1), "round counter skipped")
	`AESD_ASSERT(a_result_src, $rose(out_valid_q) |-> $past(state_q == ST_ROUND),
		"result without a final round")
	`AESD_ASSERT_NEXT(a_finish_blocked, (finish && out_valid_q && !rsp.ready),
		1'b0, "result overwritten")
endmodule

>>> tb/tb.sv
// self-checking testbench of aes_block_decrypt, the aes-128 inverse cipher
// depends on aesd_pkg, aesd_ifs and the rtl top level; predicts each block in place
`timescale 1ns / 100ps

module tb;
	import aesd_pkg::*;

	localparam int ROUNDS    = 10;
	localparam int KEY_SLOTS = 2 * (ROUNDS + 1);
	localparam int CYC_LIMIT = 300000;
	localparam int DRAIN_CYC = 2 * (ROUNDS + 2) + 4;

	logic clk;
	logic arst_n;

	aesd_req_if req_ch ();
	aesd_rsp_if rsp_ch ();

	aes_block_decrypt #(.ROUNDS(ROUNDS)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	// predictor state: own copy of the round key store
	logic [63:0]  key_mem [KEY_SLOTS];
	logic [127:0] plain_q [$];
	int           n_errors;
	int           n_cycles;
	int           rx_press;
	bit           no_idle;

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// gf(2^8) multiply by shift and reduce
	function automatic logic [7:0] gmul8(input logic [7:0] a, input logic [7:0] m);
		logic [7:0] acc;
		logic [7:0] sh;
		acc = 8'h00;
		sh  = a;
		for (int i = 0; i < 8; i++) begin
			if (m[i]) acc ^= sh;
			sh = (sh << 1) ^ (sh[7] ? 8'h1B : 8'h00);
		end
		return acc;
	endfunction

	// full inverse cipher on one block, byte n at row n%4, column n/4
	function automatic logic [127:0] decrypt_block(input logic [127:0] cipher);
		logic [7:0]   st [16];
		logic [7:0]   tmp [16];
		logic [127:0] rk;
		logic [127:0] outv;
		for (int i = 0; i < 16; i++) st[i] = cipher[127-8*i -: 8];
		for (int rnd = ROUNDS; rnd >= 0; rnd--) begin
			if (rnd != ROUNDS) begin
				// inverse shift rows and inverse sbox
				for (int r = 0; r < 4; r++)
					for (int c = 0; c < 4; c++)
						tmp[r+4*c] = INV_SBOX[st[r+4*((c+4-r)%4)]];
				st = tmp;
			end
			// add round key
			rk = {key_mem[2*rnd], key_mem[2*rnd+1]};
			for (int i = 0; i < 16; i++) st[i] ^= rk[127-8*i -: 8];
			// inverse mix columns except around the first and last key add
			if (rnd != ROUNDS && rnd != 0) begin
				for (int c = 0; c < 4; c++)
					for (int r = 0; r < 4; r++)
						tmp[4*c+r] = gmul8(st[4*c+r], MUL_E)
							^ gmul8(st[4*c+(r+1)%4], MUL_B)
							^ gmul8(st[4*c+(r+2)%4], MUL_D)
							^ gmul8(st[4*c+(r+3)%4], MUL_9);
				st = tmp;
			end
		end
		for (int i = 0; i < 16; i++) outv[127-8*i -: 8] = st[i];
		return outv;
	endfunction

	// sends one item, updates the predictor on acceptance, then idles a random gap unless no_idle is set
	task automatic send_item(input logic op, input logic [4:0] idx,
			input logic [63:0] hi, input logic [63:0] lo);
		int gap;
		req_ch.valid     <= 1'b1;
		req_ch.operation <= op;
		req_ch.key_index <= idx;
		req_ch.data_hi   <= hi;
		req_ch.data_lo   <= lo;
		do @(posedge clk); while (!req_ch.ready);
		if (op == OP_DECRYPT)
			plain_q.push_back(decrypt_block({hi, lo}));
		else if (idx < KEY_SLOTS)
			key_mem[idx] = hi;
		gap = no_idle ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// waits out every expected block plus the engine latency
	task automatic drain();
		req_ch.valid <= 1'b0;
		while (plain_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
	endtask

	// full key store rewrite, pattern 0 random, 1 all zero, 2 all ones
	task automatic load_keys(input int pattern);
		logic [63:0] kv;
		for (int i = 0; i < KEY_SLOTS; i++) begin
			kv = (pattern == 1) ? 64'h0 : (pattern == 2) ? '1 : rand64();
			send_item(OP_LOAD, 5'(i), kv, rand64());
		end
	endtask

	task automatic test_directed();
		load_keys(0);
		send_item(OP_DECRYPT, 5'd0, 64'h0, 64'h0);
		send_item(OP_DECRYPT, 5'd31, '1, '1);
		send_item(OP_DECRYPT, 5'd21, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
		// out of range loads are dropped, the store keeps its keys
		send_item(OP_LOAD, 5'(KEY_SLOTS), '1, '1);
		send_item(OP_LOAD, 5'd31, 64'h0, '1);
		send_item(OP_DECRYPT, 5'd22, rand64(), rand64());
		// single key half replaced, highest and lowest slot
		send_item(OP_LOAD, 5'(KEY_SLOTS - 1), '1, 64'h0);
		send_item(OP_LOAD, 5'd0, 64'h0, '1);
		send_item(OP_DECRYPT, 5'd1, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210);
		drain();
	endtask

	task automatic test_key_extremes();
		load_keys(1);
		send_item(OP_DECRYPT, 5'd0, 64'h0, 64'h0);
		send_item(OP_DECRYPT, 5'd0, rand64(), rand64());
		drain();
		load_keys(2);
		send_item(OP_DECRYPT, 5'd0, '1, '1);
		send_item(OP_DECRYPT, 5'd0, rand64(), rand64());
		drain();
	endtask

	// mostly decrypts, some key rewrites and some dropped loads
	task automatic test_random(input int count);
		int done;
		int pick;
		done = 0;
		load_keys(0);
		while (done < count) begin
			pick = $urandom_range(0, 99);
			if (pick < 80) begin
				send_item(OP_DECRYPT, 5'($urandom), rand64(), rand64());
				done++;
			end else if (pick < 90) begin
				send_item(OP_LOAD, 5'($urandom_range(0, KEY_SLOTS - 1)), rand64(), rand64());
				done++;
			end else begin
				send_item(OP_LOAD, 5'($urandom_range(KEY_SLOTS, 31)), rand64(), rand64());
			end
		end
		drain();
	endtask

	task automatic test_backpressure();
		no_idle  = 1'b1;
		rx_press = 400;
		for (int i = 0; i < 20; i++)
			send_item(OP_DECRYPT, 5'($urandom), rand64(), rand64());
		no_idle = 1'b0;
		drain();
	endtask

	// receiver: random stall after each item unless no_idle is set, or a long hold-off
	int rx_hold;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_hold       <= 0;
			rsp_ch.ready  <= 1'b0;
		end else if (rx_press > 0) begin
			rx_press--;
			rsp_ch.ready <= 1'b0;
		end else if (rx_hold > 0) begin
			rx_hold      <= rx_hold - 1;
			rsp_ch.ready <= 1'b0;
		end else if (rsp_ch.valid && rsp_ch.ready && !no_idle) begin
			int n;
			n = $urandom_range(0, 18);
			rx_hold      <= (n > 0) ? n - 1 : 0;
			rsp_ch.ready <= (n == 0);
		end else begin
			rsp_ch.ready <= 1'b1;
		end
	end

	// result check against the oldest expected block
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (plain_q.size() == 0) begin
				$display("%0t: unexpected block %h_%h", $time, rsp_ch.plain_hi, rsp_ch.plain_lo);
				n_errors++;
			end else begin
				logic [127:0] exp_blk;
				exp_blk = plain_q.pop_front();
				if (rsp_ch.plain_hi !== exp_blk[127:64]) begin
					$display("%0t: plain_hi expected %h actual %h", $time,
						exp_blk[127:64], rsp_ch.plain_hi);
					n_errors++;
				end
				if (rsp_ch.plain_lo !== exp_blk[63:0]) begin
					$display("%0t: plain_lo expected %h actual %h", $time,
						exp_blk[63:0], rsp_ch.plain_lo);
					n_errors++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		n_cycles++;
		if (n_cycles > CYC_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		n_errors         = 0;
		n_cycles         = 0;
		rx_press         = 0;
		no_idle          = 1'b0;
		arst_n           = 1'b0;
		req_ch.valid     = 1'b0;
		req_ch.operation = OP_LOAD;
		req_ch.key_index = '0;
		req_ch.data_hi   = '0;
		req_ch.data_lo   = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_key_extremes();
		no_idle = 1'b1;
		test_random(60);
		no_idle = 1'b0;
		test_random(130);
		test_backpressure();
		test_random(130);
		if (plain_q.size() != 0) begin
			$display("%0t: %0d expected blocks never arrived", $time, plain_q.size());
			n_errors++;
		end
		if (n_errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
